[src/nsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and constants of the neighbourhood splat classifier.
// ----------------------------------------------------------------------------
package nsc_pkg;

	localparam int BIN_W      = 16;
	localparam int COL_OUT_W  = 10;
	localparam int ROW_W      = 16;
	localparam int FW_W       = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 16'd1024;

	localparam logic [1:0] KIND_BLACK  = 2'd0;
	localparam logic [1:0] KIND_CENTRE = 2'd1;
	localparam logic [1:0] KIND_CROSS  = 2'd2;
	localparam logic [1:0] KIND_CORNER = 2'd3;

	typedef struct packed {
		logic [1:0]           pixel_kind;
		logic [BIN_W-1:0]     bin_index;
		logic [COL_OUT_W-1:0] out_col;
		logic [ROW_W-1:0]     out_row;
	} res_t;

endpackage

[src/nsc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_in_if
// Pixel request channel: histogram value and frame start marker.
// ----------------------------------------------------------------------------
interface nsc_in_if
	import nsc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] bin_value;
	logic             frame_start;

	modport source (output valid, bin_value, frame_start, input ready);
	modport sink (input valid, bin_value, frame_start, output ready);
endinterface

[src/nsc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_out_if
// Result request channel: render class, bin and position.
// ----------------------------------------------------------------------------
interface nsc_out_if
	import nsc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [1:0]           pixel_kind;
	logic [BIN_W-1:0]     bin_index;
	logic [COL_OUT_W-1:0] out_col;
	logic [ROW_W-1:0]     out_row;

	modport source (output valid, pixel_kind, bin_index, out_col, out_row, input ready);
	modport sink (input valid, pixel_kind, bin_index, out_col, out_row, output ready);
endinterface

[src/nsc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module nsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[src/nsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_front
// Position tracking, line stores, 3x3 window and neighbourhood classification.
// ----------------------------------------------------------------------------
module nsc_front
	import nsc_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int BIN_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	input  logic [BIN_W-1:0]      in_bin,
	input  logic                  in_start,
	output logic                  in_ready,
	input  logic [QCNT_W-1:0]     q_count,
	output logic                  push,
	output res_t                  push_res
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WUB = $clog2(MAX_WIDTH + 1);
	localparam int SB  = (BIN_BITS < BIN_W) ? BIN_BITS : BIN_W;

	logic [FW_W-1:0]  width_q;
	logic [ROW_W-1:0] height_q;
	logic             clr_busy_q;
	logic [CW-1:0]    clr_addr_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [31:0]      w32;
	logic [WUB-1:0]   w_use;
	logic [ROW_W-1:0] h_use;
	logic             accept;
	logic [CW-1:0]    c;
	logic [ROW_W-1:0] r;
	logic [WUB-1:0]   oc;
	logic [ROW_W-1:0] orow;
	logic             interior;
	logic             col_wrap;
	logic [ROW_W:0]   row_inc;
	logic [SB-1:0]    v;

	logic             s1_valid;
	logic [SB-1:0]    v_s1;
	logic [CW-1:0]    idx_s1;
	logic [WUB-1:0]   oc_s1;
	logic [ROW_W-1:0] orow_s1;
	logic             int_s1;
	logic             byp_s1;
	logic [SB-1:0]    byp_up_s1;
	logic [SB-1:0]    byp_mid_s1;
	logic [SB-1:0]    win_q [6];

	logic [SB-1:0]    up_rdata;
	logic [SB-1:0]    mid_rdata;
	logic [SB-1:0]    top_c;
	logic [SB-1:0]    mid_c;
	logic             ram_we;
	logic [CW-1:0]    ram_waddr;
	logic [SB-1:0]    up_wdata;
	logic [SB-1:0]    mid_wdata;
	logic [1:0]       kind;
	logic [SB-1:0]    chosen;

	// widths in use
	always_comb begin
		w32 = 32'(width_q);
		if (w32 < 32'd3) begin
			w32 = 32'd3;
		end
		if (w32 > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end
		w_use = w32[WUB-1:0];
		h_use = (height_q < ROW_W'(3)) ? ROW_W'(3) : height_q;
	end

	assign in_ready = !clr_busy_q &&
		((QCNT_W'(q_count) + QCNT_W'(s1_valid)) < QCNT_W'(QDEPTH));
	assign accept = in_valid && in_ready;
	assign v = in_bin[SB-1:0];

	// position of the incoming pixel and of the rendered one
	always_comb begin
		c        = in_start ? '0 : col_q;
		r        = in_start ? '0 : row_q;
		oc       = (c == '0) ? (w_use - WUB'(1)) : (WUB'(c) - WUB'(1));
		orow     = (r == '0) ? (h_use - ROW_W'(1)) : (r - ROW_W'(1));
		interior = (oc != '0) && (orow != '0) && (oc < (w_use - WUB'(1))) &&
			(orow < (h_use - ROW_W'(1)));
		col_wrap = (WUB'(c) + WUB'(1)) >= w_use;
		row_inc  = {1'b0, r} + (ROW_W+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= FRAME_WIDTH_RST;
			height_q   <= FRAME_HEIGHT_RST;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			s1_valid   <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_FRAME_WIDTH: begin
						width_q <= wr_data[FW_W-1:0];
					end
					REG_FRAME_HEIGHT: begin
						height_q <= wr_data[ROW_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (clr_busy_q) begin
				if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + CW'(1);
				end
			end
			if (accept) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= (row_inc >= {1'b0, h_use}) ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= c + CW'(1);
					row_q <= r;
				end
			end
			s1_valid <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1       <= v;
			idx_s1     <= c;
			oc_s1      <= oc;
			orow_s1    <= orow;
			int_s1     <= interior;
			byp_s1     <= s1_valid && (idx_s1 == c);
			byp_up_s1  <= mid_c;
			byp_mid_s1 <= v_s1;
		end
	end

	// line stores
	assign ram_we    = clr_busy_q || s1_valid;
	assign ram_waddr = clr_busy_q ? clr_addr_q : idx_s1;
	assign up_wdata  = clr_busy_q ? '0 : mid_c;
	assign mid_wdata = clr_busy_q ? '0 : v_s1;

	nsc_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (up_wdata),
		.re    (accept),
		.raddr (c),
		.rdata (up_rdata)
	);

	nsc_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mid_wdata),
		.re    (accept),
		.raddr (c),
		.rdata (mid_rdata)
	);

	// same column written in the cycle of the read
	assign top_c = byp_s1 ? byp_up_s1 : up_rdata;
	assign mid_c = byp_s1 ? byp_mid_s1 : mid_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_valid) begin
			win_q[1] <= win_q[0];
			win_q[0] <= top_c;
			win_q[3] <= win_q[2];
			win_q[2] <= mid_c;
			win_q[5] <= win_q[4];
			win_q[4] <= v_s1;
		end
	end

	// neighbourhood priority
	always_comb begin
		kind   = KIND_BLACK;
		chosen = '0;
		if (int_s1) begin
			if (win_q[2] != '0) begin
				kind   = KIND_CENTRE;
				chosen = win_q[2];
			end else if (win_q[1] != '0) begin
				kind   = KIND_CORNER;
				chosen = win_q[1];
			end else if (win_q[0] != '0) begin
				kind   = KIND_CROSS;
				chosen = win_q[0];
			end else if (top_c != '0) begin
				kind   = KIND_CORNER;
				chosen = top_c;
			end else if (win_q[3] != '0) begin
				kind   = KIND_CROSS;
				chosen = win_q[3];
			end else if (mid_c != '0) begin
				kind   = KIND_CROSS;
				chosen = mid_c;
			end else if (win_q[5] != '0) begin
				kind   = KIND_CORNER;
				chosen = win_q[5];
			end else if (win_q[4] != '0) begin
				kind   = KIND_CROSS;
				chosen = win_q[4];
			end else if (v_s1 != '0) begin
				kind   = KIND_CORNER;
				chosen = v_s1;
			end
		end
	end

	assign push                = s1_valid;
	assign push_res.pixel_kind = kind;
	assign push_res.bin_index  = (kind == KIND_BLACK) ? '0 : (BIN_W'(chosen) - BIN_W'(1));
	assign push_res.out_col    = COL_OUT_W'(oc_s1);
	assign push_res.out_row    = orow_s1;
endmodule

[src/nsc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_queue
// Short result queue between the classifier and the output channel.
// ----------------------------------------------------------------------------
module nsc_queue
	import nsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  res_t              push_res,
	output logic [QCNT_W-1:0] count,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res
);
	res_t              buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign out_res   = buf_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_res;
		end
	end
endmodule

[src/neighbourhood_splat_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbourhood_splat_classifier
// Classifies each histogram pixel one row and column behind the stream
// from its 3x3 neighbourhood into black, centre, cross or corner.
//
//   channel   role     fields
//   pix_in    sink     bin_value, frame_start
//   res_out   source   pixel_kind, bin_index, out_col, out_row
//   wr_*      write    frame_width (index 0), frame_height (index 1)
//
// one pixel per clock sustained while the result queue has room; a result
// is offered after its request passes the registered line store read and the queue
// after reset the line stores are cleared, all MAX_WIDTH addresses, pix_in
// ready low meanwhile
// a four entry result queue lets the output stall without stopping input
// until it fills
// ----------------------------------------------------------------------------
module neighbourhood_splat_classifier
	import nsc_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int BIN_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	nsc_in_if.sink                pix_in,
	nsc_out_if.source             res_out
);
	logic [QCNT_W-1:0] q_count;
	logic              push;
	res_t              push_res;
	res_t              out_res;

	nsc_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.BIN_BITS  (BIN_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_valid (pix_in.valid),
		.in_bin   (pix_in.bin_value),
		.in_start (pix_in.frame_start),
		.in_ready (pix_in.ready),
		.q_count  (q_count),
		.push     (push),
		.push_res (push_res)
	);

	nsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.count     (q_count),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.out_res   (out_res)
	);

	assign res_out.pixel_kind = out_res.pixel_kind;
	assign res_out.bin_index  = out_res.bin_index;
	assign res_out.out_col    = out_res.out_col;
	assign res_out.out_row    = out_res.out_row;
endmodule

[tb/nsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_checker
// Watches the pixel, result and register ports of the splat classifier,
// keeps its own copy of the line stores, window and position counters,
// predicts the class of every accepted pixel request and compares each
// result request in order against the oldest prediction.
// ----------------------------------------------------------------------------
module nsc_checker
	import nsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	nsc_in_if                     pix,
	nsc_out_if                    res,
	output int                    fail_count,
	output int                    pending
);

	localparam int LINE_DEPTH = 1024;
	localparam int REPORT_MAX = 20;
	localparam int NB_ORDER [8] = '{0, 1, 2, 3, 5, 6, 7, 8};

	logic [BIN_W-1:0] upper_line [LINE_DEPTH];
	logic [BIN_W-1:0] middle_line [LINE_DEPTH];
	logic [BIN_W-1:0] window_q [6];
	int unsigned      next_col;
	int unsigned      next_row;
	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;
	res_t             expected_results [$];
	res_t             got;
	res_t             want;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic res_t classify_pixel(input logic [BIN_W-1:0] v, input logic start);
		int unsigned      w;
		int unsigned      h;
		int unsigned      c;
		int unsigned      r;
		int unsigned      idx;
		int unsigned      oc;
		int unsigned      orow;
		int               k;
		logic [BIN_W-1:0] top_c;
		logic [BIN_W-1:0] mid_c;
		logic [BIN_W-1:0] pick;
		logic [BIN_W-1:0] nb [9];
		logic [1:0]       kind;
		res_t             outcome;
		w = 32'(frame_width_q);
		if (w < 3) w = 3;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		h = 32'(frame_height_q);
		if (h < 3) h = 3;
		if (start) begin
			next_col = 0;
			next_row = 0;
		end
		c = next_col;
		r = next_row;
		idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
		top_c = upper_line[idx];
		mid_c = middle_line[idx];
		// row-major 3x3: top-left first, bottom-right is the new pixel
		nb[0] = window_q[1];
		nb[1] = window_q[0];
		nb[2] = top_c;
		nb[3] = window_q[3];
		nb[4] = window_q[2];
		nb[5] = mid_c;
		nb[6] = window_q[5];
		nb[7] = window_q[4];
		nb[8] = v;
		oc = (c == 0) ? w - 1 : c - 1;
		orow = (r == 0) ? h - 1 : r - 1;
		kind = KIND_BLACK;
		pick = '0;
		if (oc >= 1 && orow >= 1 && oc < w - 1 && orow < h - 1) begin
			if (nb[4] != '0) begin
				kind = KIND_CENTRE;
				pick = nb[4];
			end else begin
				for (k = 0; k < 8; k++) begin
					if (kind == KIND_BLACK && nb[NB_ORDER[k]] != '0) begin
						pick = nb[NB_ORDER[k]];
						kind = (NB_ORDER[k] % 2 == 1) ? KIND_CROSS : KIND_CORNER;
					end
				end
			end
		end
		upper_line[idx] = mid_c;
		middle_line[idx] = v;
		window_q[1] = window_q[0];
		window_q[0] = top_c;
		window_q[3] = window_q[2];
		window_q[2] = mid_c;
		window_q[5] = window_q[4];
		window_q[4] = v;
		if (c + 1 >= w) begin
			next_col = 0;
			next_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
		end
		outcome.pixel_kind = kind;
		outcome.bin_index = (kind == KIND_BLACK) ? '0 : pick - 1'b1;
		outcome.out_col = oc[COL_OUT_W-1:0];
		outcome.out_row = orow[ROW_W-1:0];
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (upper_line[i]) upper_line[i] = '0;
			foreach (middle_line[i]) middle_line[i] = '0;
			foreach (window_q[i]) window_q[i] = '0;
			next_col = 0;
			next_row = 0;
			frame_width_q = FRAME_WIDTH_RST;
			frame_height_q = FRAME_HEIGHT_RST;
			expected_results.delete();
			pending = 0;
		end else begin
			if (res.valid && res.ready) begin
				got.pixel_kind = res.pixel_kind;
				got.bin_index = res.bin_index;
				got.out_col = res.out_col;
				got.out_row = res.out_row;
				if (expected_results.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("%0t: unexpected result, got kind %0d bin %0d col %0d row %0d",
							$time, got.pixel_kind, got.bin_index, got.out_col, got.out_row);
					fail_count = fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (got.pixel_kind !== want.pixel_kind || got.bin_index !== want.bin_index
							|| got.out_col !== want.out_col || got.out_row !== want.out_row) begin
						if (fail_count < REPORT_MAX)
							$display({"%0t: result mismatch, expected kind %0d bin %0d col %0d",
								" row %0d, got kind %0d bin %0d col %0d row %0d"},
								$time, want.pixel_kind, want.bin_index, want.out_col,
								want.out_row, got.pixel_kind, got.bin_index, got.out_col,
								got.out_row);
						fail_count = fail_count + 1;
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_FRAME_WIDTH: frame_width_q = wr_data[FW_W-1:0];
					REG_FRAME_HEIGHT: frame_height_q = wr_data[ROW_W-1:0];
					default: ;
				endcase
			end
			if (pix.valid && pix.ready)
				expected_results.insert(expected_results.size(),
					classify_pixel(pix.bin_value, pix.frame_start));
			pending = expected_results.size();
		end
	end

endmodule

[tb/tb_neighbourhood_splat_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neighbourhood_splat_classifier
// Drives small directed frames covering the centre, cross and corner cases,
// then random frames of varying sparsity and size, clamped and out-of-range
// register settings, continued frames after a size change, stray frame
// starts and one long pass at full width. Both channels idle at random; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_neighbourhood_splat_classifier;
	import nsc_pkg::*;

	localparam int RANDOM_PIXELS = 900;
	localparam int PHASE_CAP     = 150;
	localparam int WIDE_ROW      = 1024;
	localparam int WIDE_CAP      = RANDOM_PIXELS / 2;
	localparam logic [BIN_W-1:0] DIRECTED_PIX [27] = '{
		16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000
	};

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  pix_taken;
	logic                  res_taken;
	bit                    calm;
	int                    fail_count;
	int                    pending;

	nsc_in_if  pix_ch ();
	nsc_out_if res_ch ();

	neighbourhood_splat_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pix_in   (pix_ch),
		.res_out  (res_ch)
	);

	nsc_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.pix        (pix_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_taken <= 1'b0;
			res_taken <= 1'b0;
		end else begin
			pix_taken <= pix_ch.valid && pix_ch.ready;
			res_taken <= res_ch.valid && res_ch.ready;
		end
	end

	function automatic logic [BIN_W-1:0] draw_bin(input int zero_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < zero_pct) return '0;
		roll = $urandom_range(0, 3);
		if (roll == 0) return 16'h0001;
		if (roll == 1) return 16'hFFFF;
		return BIN_W'($urandom);
	endfunction

	function automatic int clamp_dim(input int value, input int top);
		if (value < 3) return 3;
		if (value > top) return top;
		return value;
	endfunction

	task automatic send_pixel(input logic [BIN_W-1:0] v, input logic start);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			pix_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.bin_value = v;
		pix_ch.frame_start = start;
		do @(negedge clk); while (!pix_taken);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic settle();
		pix_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_frames(input int fw, input int fh, input int frames, input bit with_start,
			input int zero_pct, input int cap, inout int sent);
		int frame_pixels;
		int n;
		int i;
		logic start;
		frame_pixels = fw * fh;
		n = frames * frame_pixels;
		if (n > cap) n = cap;
		for (i = 0; i < n; i++) begin
			start = (i % frame_pixels == 0) && (with_start || i > 0);
			// stray frame start in mid-frame
			if ($urandom_range(0, 99) == 0) start = 1'b1;
			send_pixel(draw_bin(zero_pct), start);
			sent++;
		end
	endtask

	// result side: random stall before each request
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(negedge clk); while (!res_taken);
		end
	end

	initial begin
		int sent;
		int phase;
		int mode;
		int fw;
		int fh;
		int i;
		logic [CFG_DATA_W-1:0] data;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_FRAME_WIDTH;
		wr_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.bin_value = '0;
		pix_ch.frame_start = 1'b0;
		calm = 1'b0;
		sent = 0;
		fw = 3;
		fh = 3;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// smallest frame: centre, bottom-right corner only, bottom edge only
		write_reg(REG_FRAME_WIDTH, 16'd3);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		for (i = 0; i < 27; i++)
			send_pixel(DIRECTED_PIX[i], i % 9 == 0);

		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			settle();
			calm = ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				// full-width pass: width clamped down from the top of its field
				write_reg(REG_FRAME_WIDTH, 16'hFFFF);
				write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
				fw = WIDE_ROW;
				fh = 65535;
				calm = 1'b1;
				run_frames(fw, fh, 1, 1'b1, 50, WIDE_CAP, sent);
			end else begin
				mode = $urandom_range(0, 9);
				if (mode < 8 || phase == 0) begin
					if (mode == 0)
						fw = $urandom_range(0, 2);
					else if (mode == 1)
						fw = $urandom_range(1025, 2047);
					else
						fw = $urandom_range(3, 10);
					data = fw[CFG_DATA_W-1:0];
					data[CFG_DATA_W-1:FW_W] = (CFG_DATA_W - FW_W)'($urandom);
					write_reg(REG_FRAME_WIDTH, data);
				end
				mode = $urandom_range(0, 9);
				if (mode < 8 || phase == 0) begin
					if (mode == 0)
						fh = $urandom_range(0, 2);
					else if (mode == 1)
						fh = 65535;
					else
						fh = $urandom_range(3, 8);
					write_reg(REG_FRAME_HEIGHT, fh[CFG_DATA_W-1:0]);
				end
				run_frames(clamp_dim(fw, WIDE_ROW), clamp_dim(fh, 65535), $urandom_range(1, 3),
					$urandom_range(0, 3) != 0, ($urandom_range(0, 1) == 0) ? 50 : 85,
					PHASE_CAP, sent);
			end
			phase++;
		end

		pix_ch.valid = 1'b0;
		calm = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("tb_neighbourhood_splat_classifier passed");
		else
			$display("tb_neighbourhood_splat_classifier failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_neighbourhood_splat_classifier failed");
		$finish;
	end

endmodule
